### hdl/udiv32_pkg.sv
// Shared types and constants for the unsigned 32-bit divider.
package udiv32_pkg;

   // Width of the dividend, divisor and quotient fields on the ports.
   localparam int FIELD_W = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } udiv32_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } udiv32_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic last_step;
   } udiv32_status_type;

endpackage

### hdl/udiv32_dpath.sv
// Datapath of the divider: operand, partial remainder and quotient registers, the
// shift-subtract step, the step counter and the result register.
module udiv32_dpath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic [udiv32_pkg::FIELD_W-1:0]   req_dividend,
   input  logic [udiv32_pkg::FIELD_W-1:0]   req_divisor,
   input  udiv32_pkg::udiv32_cmd_type       cmd,
   output udiv32_pkg::udiv32_status_type    status,
   output logic [udiv32_pkg::FIELD_W-1:0]   rsp_quotient,
   output logic                             rsp_divide_by_zero
);
   import udiv32_pkg::*;

   localparam int CW = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] num;
   logic [DATA_WIDTH-1:0] den;
   logic [FIELD_W-1:0]    quo_field;

   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  dz_ff, dz_in;
   logic [FIELD_W-1:0]    out_quo_ff, out_quo_in;
   logic                  out_dz_ff, out_dz_in;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH+1:0] diff;
   logic                  fits;

   // Operands are reduced to (or widened to) the arithmetic width; the quotient is
   // fitted back into the field width.
   if (DATA_WIDTH <= FIELD_W) begin : g_narrow
      assign num       = req_dividend[DATA_WIDTH-1:0];
      assign den       = req_divisor[DATA_WIDTH-1:0];
      assign quo_field = {{(FIELD_W-DATA_WIDTH){1'b0}}, quo_ff};
   end else begin : g_wide
      assign num       = {{(DATA_WIDTH-FIELD_W){1'b0}}, req_dividend};
      assign den       = {{(DATA_WIDTH-FIELD_W){1'b0}}, req_divisor};
      assign quo_field = quo_ff[FIELD_W-1:0];
   end

   // One restoring step: bring down the next dividend bit and try the subtraction.
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~diff[DATA_WIDTH+1];

   always_comb begin
      den_in     = den_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      dz_in      = dz_ff;
      out_quo_in = out_quo_ff;
      out_dz_in  = out_dz_ff;
      if (cmd.load) begin
         den_in = den;
         rem_in = '0;
         quo_in = num;
         cnt_in = CW'(DATA_WIDTH - 1);
         dz_in  = (den == '0);
      end else if (cmd.step) begin
         rem_in = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.publish) begin
         // A zero divisor lets every trial subtraction succeed, so the quotient
         // comes out as all ones without a special path.
         out_quo_in = quo_field;
         out_dz_in  = dz_ff;
      end
   end

   always_ff @(posedge clock) begin
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      dz_ff      <= dz_in;
      out_quo_ff <= out_quo_in;
      out_dz_ff  <= out_dz_in;
   end

   assign status.last_step  = (cnt_ff == '0);
   assign rsp_quotient       = out_quo_ff;
   assign rsp_divide_by_zero = out_dz_ff;

endmodule

### hdl/udiv32_ctrl.sv
// Controller of the divider: sequencing state machine and result valid flag.
module udiv32_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  udiv32_pkg::udiv32_status_type  status,
   output udiv32_pkg::udiv32_cmd_type     cmd
);
   import udiv32_pkg::*;

   udiv32_state_type state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   // The result register can take a new quotient when empty or being drained.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_RUN;
         ST_RUN:  if (status.last_step) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.publish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_RUN:  cmd.step = 1'b1;
         ST_DONE: cmd.publish = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/unsigned_divider_32_core.sv
// Top level of the unsigned 32-bit divider: controller, datapath and checks.
//
//   Channel   Direction   Handshake               Payload
//   req       in          req_valid / req_stall   req_dividend, req_divisor
//   rsp       out         rsp_valid / rsp_stall   rsp_quotient, rsp_divide_by_zero
//
// For each item the operands are loaded first, then the shared shift-subtract unit
// produces the DATA_WIDTH bits of the quotient, one bit of quotient per cycle, and
// finally the quotient is moved into the result register.
// The result register lets the next item be accepted and divided while the previous
// quotient still waits on rsp_stall; the unit only waits if that result is still
// held when the next quotient is ready to publish.
// Reset is synchronous and clears the state machine and the result valid flag; the
// arithmetic registers carry no reset.
module unsigned_divider_32_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [udiv32_pkg::FIELD_W-1:0]   req_dividend,
   input  logic [udiv32_pkg::FIELD_W-1:0]   req_divisor,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [udiv32_pkg::FIELD_W-1:0]   rsp_quotient,
   output logic                             rsp_divide_by_zero
);
   import udiv32_pkg::*;

   // Quotient expected for a zero divisor: all ones at the arithmetic width, fitted
   // to the field width.
   localparam logic [FIELD_W-1:0] DZ_QUOT = (DATA_WIDTH >= FIELD_W) ? '1 :
      FIELD_W'((64'd1 << DATA_WIDTH) - 64'd1);

   udiv32_cmd_type    cmd;
   udiv32_status_type status;

   // The controller sequences load, steps and publish; it owns the handshakes.
   udiv32_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the operands, runs the restoring division and keeps the
   // result register.
   udiv32_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .cmd                (cmd),
      .status             (status),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

`ifndef ASSERT_OFF
   // Once an item is taken, the unit is busy for the next cycle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted again right after an accept");

   // A publish always leaves a valid result on the output.
   a_publish_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("published result not presented");

   // A zero divisor must come out as an all-ones quotient.
   a_dz_quotient : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_quotient == DZ_QUOT))
      else $error("divide by zero without an all-ones quotient");

   // Load never happens in the same cycle as a publish or a step.
   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && (cmd.publish || cmd.step)))
      else $error("load overlaps another command");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the unsigned 32-bit divider core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import udiv32_pkg::*;

   // Clock period, reset length and the bounds of the run.
   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 2;
   // After the last result, keep the clock running so that anything stray can show up.
   localparam int SETTLE_CYCLES = 80;
   // The timeout leaves ample margin over the slowest correct run.
   localparam int TIMEOUT_NS    = 10_000_000;
   localparam int MAX_IDLE      = 11;
   localparam int LONG_HOLD     = 400;

   // One predicted result item: what the divider must return for one request.
   typedef struct {
      logic [FIELD_W-1:0] quotient;
      logic               divide_by_zero;
   } quotient_entry_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [FIELD_W-1:0] req_dividend;
   logic [FIELD_W-1:0] req_divisor;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [FIELD_W-1:0] rsp_quotient;
   logic               rsp_divide_by_zero;

   // Quotients the divider still owes us, oldest first.
   quotient_entry_type pending_quotients[$];
   int                 mismatch_count = 0;

   // Idle knobs. The sender and the receiver each draw a wait of 0 to the
   // current maximum before every item; setting a maximum to 0 gives stretches
   // with no idling at all. A nonzero hold request is added to the receiver's
   // drawn wait before it takes its next item.
   int send_gap_max  = MAX_IDLE;
   int recv_wait_max = MAX_IDLE;
   int hold_request  = 0;

   unsigned_divider_32_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Integer division at the port width. A zero divisor gives all ones and
   // raises the error flag instead of faulting.
   function automatic quotient_entry_type predict_quotient(
         input logic [FIELD_W-1:0] dividend,
         input logic [FIELD_W-1:0] divisor);
      quotient_entry_type entry;
      if (divisor == '0) begin
         entry.quotient       = '1;
         entry.divide_by_zero = 1'b1;
      end else begin
         entry.quotient       = dividend / divisor;
         entry.divide_by_zero = 1'b0;
      end
      return entry;
   endfunction

   // Offers one item after a random gap and holds it until the divider takes it.
   // The valid line changes only at falling edges, and at most once per edge: a
   // zero gap keeps it high straight into the next item.
   task automatic send_item(input logic [FIELD_W-1:0] dividend,
                            input logic [FIELD_W-1:0] divisor);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_dividend <= dividend;
      req_divisor  <= divisor;
      // The item is accepted at the first rising edge that finds stall low.
      do @(posedge clock); while (req_stall);
      pending_quotients.push_back(predict_quotient(dividend, divisor));
   endtask

   // Drops valid and waits until every outstanding quotient has been returned.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_quotients.size() != 0) @(posedge clock);
   endtask

   // Draws operands in a range of shapes. Besides uniform values this favors
   // divisors that fit in 16 bits and ones that do not, zero divisors, powers
   // of two, divisors close to the dividend, exact multiples and dividends
   // shifted down by up to 4 bits.
   task automatic pick_operands(output logic [FIELD_W-1:0] dividend,
                                output logic [FIELD_W-1:0] divisor);
      int                 shape;
      logic [FIELD_W-1:0] factor;
      shape    = $urandom_range(0, 15);
      dividend = $urandom;
      case (shape)
         0, 1: begin
            divisor = $urandom;
         end
         2, 3: begin
            divisor = $urandom_range(1, 16'hFFFF);
         end
         4, 5: begin
            divisor = $urandom >> $urandom_range(0, FIELD_W - 1);
         end
         6: begin
            divisor = '0;
         end
         7: begin
            divisor = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
         end
         8: begin
            dividend = $urandom >> $urandom_range(0, FIELD_W - 1);
            divisor  = $urandom >> $urandom_range(0, FIELD_W - 1);
         end
         9: begin
            divisor = dividend + $urandom_range(0, 2) - 1;
         end
         10: begin
            divisor  = ($urandom >> $urandom_range(0, 24)) | FIELD_W'(1);
            factor   = $urandom >> $urandom_range(0, FIELD_W - 1);
            dividend = factor * divisor - $urandom_range(0, 1);
         end
         11: begin
            divisor = $urandom | 32'h0001_0000;
         end
         12: begin
            divisor = $urandom | 32'h8000_0000;
         end
         13: begin
            dividend = $urandom | 32'h8000_0000;
            divisor  = $urandom_range(1, 3);
         end
         default: begin
            divisor  = $urandom;
            dividend = $urandom >> $urandom_range(0, 4);
         end
      endcase
   endtask

   // Hand-picked items: field extremes, the zero divisor, a divisor above the
   // dividend, and operands around the 16-bit and top-bit boundaries.
   task automatic test_directed_cases();
      send_item(32'h0000_0000, 32'h0000_0001);
      send_item(32'hFFFF_FFFF, 32'h0000_0001);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'h0000_0000, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'h0000_0000);
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'h0000_0005, 32'h0000_0000);
      send_item(32'h0000_0001, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_item(32'h8000_0000, 32'h0000_0001);
      send_item(32'h8000_0000, 32'h8000_0000);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'hFFFF_FFFF, 32'h0000_0002);
      send_item(32'hFFFF_FFFF, 32'h0000_FFFF);
      send_item(32'hFFFF_FFFF, 32'h0001_0000);
      send_item(32'h1234_5678, 32'h0000_8000);
      send_item(32'hFFFF_0000, 32'h0000_FFFF);
      send_item(32'h0000_0064, 32'h0000_0007);
      send_item(32'h0000_0007, 32'h0000_0064);
      send_item(32'hDEAD_BEEF, 32'h0001_2345);
      send_item(32'h5555_5555, 32'hAAAA_AAAA);
   endtask

   // The bulk of the run: shaped random operands with random idling on both sides.
   task automatic test_random_operands(input int count);
      logic [FIELD_W-1:0] dividend;
      logic [FIELD_W-1:0] divisor;
      repeat (count) begin
         pick_operands(dividend, divisor);
         send_item(dividend, divisor);
      end
   endtask

   // Neither side idles, so items follow each other as fast as the divider allows.
   task automatic test_back_to_back(input int count);
      send_gap_max  = 0;
      recv_wait_max = 0;
      test_random_operands(count);
      send_gap_max  = MAX_IDLE;
      recv_wait_max = MAX_IDLE;
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // items, so the result register fills and the divider stalls its input.
   task automatic test_output_backpressure(input int count);
      wait_for_drain();
      hold_request = LONG_HOLD;
      send_gap_max = 0;
      test_random_operands(count);
      send_gap_max = MAX_IDLE;
   endtask

   // Short bursts, each followed by a pause until every quotient has come back,
   // so the divider regularly starts from idle.
   task automatic test_drain_pause(input int bursts, input int burst_len);
      repeat (bursts) begin
         test_random_operands(burst_len);
         wait_for_drain();
      end
   endtask

   // Receiver: before each item it stalls for a random number of cycles (plus
   // any long hold that a test has asked for), then takes the next result.
   // A pending hold request cuts the wait short so that it starts promptly.
   initial begin : result_receiver
      int stall_cycles;
      rsp_stall = 1'b1;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         stall_cycles = hold_request + $urandom_range(0, recv_wait_max);
         hold_request = 0;
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && hold_request == 0);
      end
   end

   // Compares every accepted result item with the oldest prediction.
   always @(posedge clock) begin
      quotient_entry_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_quotients.size() == 0) begin
            $error("unexpected result item: rsp_quotient %h, rsp_divide_by_zero %b",
                   rsp_quotient, rsp_divide_by_zero);
            mismatch_count++;
         end else begin
            expected = pending_quotients.pop_front();
            if (rsp_quotient !== expected.quotient) begin
               $error("rsp_quotient: expected %h, got %h", expected.quotient, rsp_quotient);
               mismatch_count++;
            end
            if (rsp_divide_by_zero !== expected.divide_by_zero) begin
               $error("rsp_divide_by_zero: expected %b, got %b",
                      expected.divide_by_zero, rsp_divide_by_zero);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Main sequence: reset once, run each test in turn, then drain and report.
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_dividend = '0;
      req_divisor  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_operands(1024);
      test_back_to_back(150);
      test_output_backpressure(16);
      test_drain_pause(7, 20);

      // Every item is in; wait for the last quotients, then give the divider
      // time to show any result it should not produce.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
